// ===== rtl/afk_pkg.sv =====
// Shared types, widths and constants for the seven-joint forward kinematics block.
// No dependencies; compiled first.
package afk_pkg;

	localparam int NUM_JOINTS = 6;
	localparam int ROT_W      = 32;
	localparam int PROD_W     = 2 * ROT_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int POS_W      = 30;
	localparam int OFF_W      = 18;
	localparam int TERM_W     = ROT_W + OFF_W + 1;
	localparam int OUT_W      = 24;
	localparam int T_W        = 35;
	localparam int R_W        = 31;
	localparam int MAG_W      = 30;
	localparam int P_W        = 31;
	localparam int STEPS      = 5;

	localparam int SC_LAT   = 20;
	localparam int CELL_LAT = 2;
	localparam int PIPE_LAT = SC_LAT + NUM_JOINTS * CELL_LAT + 2;

	localparam longint Q30_ONE       = 64'sd1073741824;
	localparam longint Q30_PI        = 64'sd3373259426;
	localparam longint Q30_HALFPI    = 64'sd1686629713;
	localparam longint Q30_QUARTERPI = 64'sd843314857;
	localparam longint RCP_ONE       = 64'sd4294967296;

	localparam int SIN_DIV [STEPS] = '{110, 72, 42, 20, 6};
	localparam int COS_DIV [STEPS] = '{90, 56, 30, 12, 2};

	// bit j set: rotation pattern [[c,0,s],[s,0,-c],[0,1,0]]
	localparam logic [NUM_JOINTS-1:0] TWIST = 6'b011001;

	localparam logic [OFF_W-1:0] SHOULDER_RESET = 18'd26214;
	localparam logic [OFF_W-1:0] ELBOW_RESET    = 18'd25559;
	localparam logic [OFF_W-1:0] FLANGE_RESET   = 18'd13107;

	typedef enum logic [1:0] {
		REG_SHOULDER = 2'd0,
		REG_ELBOW    = 2'd1,
		REG_FLANGE   = 2'd2
	} reg_index_t;

	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	typedef logic signed [ROT_W-1:0] ent_t;
	typedef logic signed [POS_W-1:0] pos_ent_t;
	typedef ent_t rot_t [3][3];
	typedef pos_ent_t pos_t [3];

	typedef struct packed {
		logic [MAG_W-1:0] z;
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic [1:0]       quad;
	} sc_carry_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] position_x;
		logic signed [OUT_W-1:0] position_y;
		logic signed [OUT_W-1:0] position_z;
	} out_item_t;

	localparam logic signed [SUM_W-1:0]  HALF_Q30  = SUM_W'(64'sd536870912);
	localparam logic signed [TERM_W-1:0] HALF_TERM = TERM_W'(64'sd2097152);

	function automatic ent_t round_q30(input logic signed [SUM_W-1:0] x);
		logic signed [SUM_W-1:0] y;
		y = (x + HALF_Q30) >>> 30;
		return ROT_W'(y);
	endfunction

	function automatic pos_ent_t round_term(input logic signed [TERM_W-1:0] x);
		logic signed [TERM_W-1:0] y;
		y = (x + HALF_TERM) >>> 22;
		return POS_W'(y);
	endfunction

endpackage

// ===== rtl/afk_in_if.sv =====
// Input channel: seven joint angles with valid/ready handshake.
// Stand-alone interface, no package dependency.
interface afk_in_if #(parameter int ANGLE_WIDTH = 16);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_one;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_two;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_three;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_four;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_five;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_six;
	logic signed [ANGLE_WIDTH-1:0] angle_joint_seven;

	modport source (output valid, angle_joint_one, angle_joint_two, angle_joint_three,
		angle_joint_four, angle_joint_five, angle_joint_six, angle_joint_seven,
		input ready);
	modport sink (input valid, angle_joint_one, angle_joint_two, angle_joint_three,
		angle_joint_four, angle_joint_five, angle_joint_six, angle_joint_seven,
		output ready);
endinterface

// ===== rtl/afk_out_if.sv =====
// Output channel: end-effector position with valid/ready handshake.
// Stand-alone interface, no package dependency.
interface afk_out_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] position_x;
	logic signed [23:0] position_y;
	logic signed [23:0] position_z;

	modport source (output valid, position_x, position_y, position_z, input ready);
	modport sink (input valid, position_x, position_y, position_z, output ready);
endinterface

// ===== rtl/afk_sincos.sv =====
// Pipelined fixed-point cosine and sine of one joint angle, Q30 results.
// Depends on afk_pkg; every stage advances only while en is high.
module afk_sincos #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output afk_pkg::ent_t                 cosine,
	output afk_pkg::ent_t                 sine
);
	import afk_pkg::*;

	localparam int SH = 33 - ANGLE_WIDTH;
	localparam logic signed [T_W-1:0] PI_T  = T_W'(Q30_PI);
	localparam logic signed [T_W-1:0] TPI_T = T_W'(2 * Q30_PI);
	localparam logic signed [T_W-1:0] HP_T  = T_W'(Q30_HALFPI);
	localparam logic signed [T_W-1:0] QP_T  = T_W'(Q30_QUARTERPI);
	localparam logic [P_W-1:0] ONE_P = P_W'(Q30_ONE);

	logic signed [T_W-1:0] ta, tw, t_s1, u, qhp, r_full;
	logic [2:0]            q;
	logic signed [R_W-1:0] r_s2;
	logic [1:0]            quad_s2;
	logic [MAG_W-1:0]      mag;
	logic [2*MAG_W-1:0]    zprod;

	logic [P_W-1:0] psin [STEPS+1];
	logic [P_W-1:0] pcos [STEPS+1];
	sc_carry_t      carry [STEPS+1];

	always_comb begin
		ta = T_W'(angle) <<< SH;
		tw = ta;
		if (ta > PI_T) begin
			tw = ta - TPI_T;
		end else if (ta < -PI_T) begin
			tw = ta + TPI_T;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= tw;
		end
	end

	always_comb begin
		u = t_s1 + PI_T + QP_T;
		q = {2'b0, u >= HP_T} + {2'b0, u >= 2 * HP_T} + {2'b0, u >= 3 * HP_T}
			+ {2'b0, u >= 4 * HP_T};
		case (q)
			3'd0:    qhp = '0;
			3'd1:    qhp = HP_T;
			3'd2:    qhp = 2 * HP_T;
			3'd3:    qhp = 3 * HP_T;
			default: qhp = 4 * HP_T;
		endcase
		r_full = t_s1 + PI_T - qhp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2    <= R_W'(r_full);
			quad_s2 <= 2'(q + 3'd2);
		end
	end

	always_comb begin
		mag   = r_s2[R_W-1] ? MAG_W'(-r_s2) : MAG_W'(r_s2);
		zprod = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry[0] <= '{z: zprod[2*MAG_W-1:30], mag: mag, neg: r_s2[R_W-1],
				quad: quad_s2};
			psin[0]  <= ONE_P;
			pcos[0]  <= ONE_P;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam int SD = SIN_DIV[k];
		localparam int CD = COS_DIV[k];
		localparam logic [31:0] SRCP = 32'(RCP_ONE / SD);
		localparam logic [31:0] CRCP = 32'(RCP_ONE / CD);

		sc_carry_t        carry_s1, carry_s2;
		logic [MAG_W-1:0] xs_s1, xc_s1, xs_s2, xc_s2;
		logic [61:0]      ms_s2, mc_s2;
		logic [60:0]      prs, prc;
		logic [29:0]      q0s, q0c;
		logic [31:0]      rems, remc;
		logic [P_W-1:0]   qs, qc;

		always_comb begin
			prs = {31'b0, carry[k].z} * {30'b0, psin[k]};
			prc = {31'b0, carry[k].z} * {30'b0, pcos[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				carry_s1 <= carry[k];
				xs_s1    <= prs[59:30];
				xc_s1    <= prc[59:30];
				carry_s2 <= carry_s1;
				xs_s2    <= xs_s1;
				xc_s2    <= xc_s1;
				ms_s2    <= {32'b0, xs_s1} * {30'b0, SRCP};
				mc_s2    <= {32'b0, xc_s1} * {30'b0, CRCP};
			end
		end

		always_comb begin
			q0s  = ms_s2[61:32];
			q0c  = mc_s2[61:32];
			rems = {2'b0, xs_s2} - 32'({2'b0, q0s} * 32'(SD));
			remc = {2'b0, xc_s2} - 32'({2'b0, q0c} * 32'(CD));
			qs   = {1'b0, q0s} + {30'b0, rems >= 32'(SD)};
			qc   = {1'b0, q0c} + {30'b0, remc >= 32'(CD)};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				carry[k+1] <= carry_s2;
				psin[k+1]  <= ONE_P - qs;
				pcos[k+1]  <= ONE_P - qc;
			end
		end
	end

	logic [60:0]    srp;
	ent_t           sr_s19, cr_s19, srs;
	logic [1:0]     quad_s19;

	assign srp = {31'b0, carry[STEPS].mag} * {30'b0, psin[STEPS]};

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s19   <= carry[STEPS].neg ? -ROT_W'(srp[60:30]) : ROT_W'(srp[60:30]);
			cr_s19   <= ROT_W'(pcos[STEPS]);
			quad_s19 <= carry[STEPS].quad;
		end
	end

	assign srs = sr_s19;

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s19)
				2'd0: begin
					cosine <= cr_s19;
					sine   <= srs;
				end
				2'd1: begin
					cosine <= -srs;
					sine   <= cr_s19;
				end
				2'd2: begin
					cosine <= -cr_s19;
					sine   <= -srs;
				end
				default: begin
					cosine <= srs;
					sine   <= -cr_s19;
				end
			endcase
		end
	end
endmodule

// ===== rtl/afk_joint_cell.sv =====
// One link of the transform chain: rotates the running frame by one joint and
// adds that joint's offset to the position. Depends on afk_pkg; advances only while en is high.
module afk_joint_cell (
	input  logic                    clk,
	input  logic                    en,
	input  logic                    twist,
	input  logic [afk_pkg::OFF_W-1:0] offset,
	input  afk_pkg::ent_t           cosine,
	input  afk_pkg::ent_t           sine,
	input  afk_pkg::rot_t           rot_in,
	input  afk_pkg::pos_t           pos_in,
	output afk_pkg::rot_t           rot_out,
	output afk_pkg::pos_t           pos_out
);
	import afk_pkg::*;

	logic signed [PROD_W-1:0] ca_s1 [3];
	logic signed [PROD_W-1:0] sb_s1 [3];
	logic signed [PROD_W-1:0] sa_s1 [3];
	logic signed [PROD_W-1:0] cb_s1 [3];
	logic signed [TERM_W-1:0] term_s1 [3];
	ent_t                     e_s1 [3];
	pos_t                     pos_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ca_s1[i]   <= cosine * rot_in[i][0];
				sb_s1[i]   <= sine * rot_in[i][1];
				sa_s1[i]   <= sine * rot_in[i][0];
				cb_s1[i]   <= cosine * rot_in[i][1];
				term_s1[i] <= rot_in[i][2] * $signed({1'b0, offset});
				e_s1[i]    <= rot_in[i][2];
				pos_s1[i]  <= pos_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rot_out[i][0] <= round_q30(SUM_W'(ca_s1[i]) + SUM_W'(sb_s1[i]));
				if (twist) begin
					rot_out[i][1] <= e_s1[i];
					rot_out[i][2] <= round_q30(SUM_W'(sa_s1[i]) - SUM_W'(cb_s1[i]));
				end else begin
					rot_out[i][1] <= -e_s1[i];
					rot_out[i][2] <= round_q30(SUM_W'(cb_s1[i]) - SUM_W'(sa_s1[i]));
				end
				pos_out[i] <= pos_s1[i] + round_term(term_s1[i]);
			end
		end
	end
endmodule

// ===== rtl/arm_forward_kinematics_7dof.sv =====
// Top level of the seven-joint forward kinematics pipeline.
// Depends on afk_pkg, afk_in_if, afk_out_if, afk_sincos and afk_joint_cell.
//
//   channel   dir  handshake        payload
//   joints    in   valid/ready      angle_joint_one .. angle_joint_seven
//   pose      out  valid/ready      position_x, position_y, position_z
//   write_*   in   write_enable     write_index, write_data (link offsets)
//
// One pose per cycle while the pipeline is not stalled. A pose passes the sine/cosine
// pipeline, then the six joint cells, then the registered flange offset sum.
// Reset clears the pipeline valid bits and the output queue and loads the offsets.
// A two-entry output queue decouples the sink; the pipeline stalls only when the
// queue is full and a result reaches its end.
module arm_forward_kinematics_7dof #(
	parameter int ANGLE_WIDTH        = 16,
	parameter int POSITION_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	afk_in_if.sink      joints,
	afk_out_if.source   pose,
	input  logic        write_enable,
	input  logic [1:0]  write_index,
	input  logic [17:0] write_data
);
	import afk_pkg::*;

	localparam int OUT_SHIFT = 24 - POSITION_FRAC_BITS;
	localparam logic signed [POS_W:0] HALF_OUT =
		(OUT_SHIFT == 0) ? '0 : (POS_W+1)'(64'sd1 <<< ((OUT_SHIFT == 0) ? 0 : OUT_SHIFT - 1));

	logic [OFF_W-1:0] shoulder_q, elbow_q, flange_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shoulder_q <= SHOULDER_RESET;
			elbow_q    <= ELBOW_RESET;
			flange_q   <= FLANGE_RESET;
		end else if (write_enable) begin
			unique case (write_index)
				REG_SHOULDER: shoulder_q <= write_data;
				REG_ELBOW:    elbow_q    <= write_data;
				REG_FLANGE:   flange_q   <= write_data;
				default: ;
			endcase
		end
	end

	logic                  adv, push, pop;
	logic [PIPE_LAT-1:0]   vld_q;
	logic [1:0]            count_q;
	logic                  wr_ptr_q, rd_ptr_q;
	out_item_t             fifo_q [2];
	out_item_t             result;

	assign adv          = !(vld_q[PIPE_LAT-1] && count_q == 2'd2);
	assign joints.ready = adv;
	assign push         = adv && vld_q[PIPE_LAT-1];
	assign pop          = pose.valid && pose.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], joints.valid};
		end
	end

	logic signed [ANGLE_WIDTH-1:0] angles [NUM_JOINTS];
	ent_t cos_w [NUM_JOINTS];
	ent_t sin_w [NUM_JOINTS];
	ent_t cell_cos [NUM_JOINTS];
	ent_t cell_sin [NUM_JOINTS];
	logic [OFF_W-1:0] joint_off [NUM_JOINTS];

	assign angles[0] = joints.angle_joint_one;
	assign angles[1] = joints.angle_joint_two;
	assign angles[2] = joints.angle_joint_three;
	assign angles[3] = joints.angle_joint_four;
	assign angles[4] = joints.angle_joint_five;
	assign angles[5] = joints.angle_joint_six;

	rot_t rot_chain [NUM_JOINTS+1];
	pos_t pos_chain [NUM_JOINTS+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pos_chain[0][i] = '0;
			for (int k = 0; k < 3; k++) begin
				rot_chain[0][i][k] = (i == k) ? ROT_W'(Q30_ONE) : '0;
			end
		end
	end

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
		afk_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sincos (
			.clk    (clk),
			.en     (adv),
			.angle  (angles[j]),
			.cosine (cos_w[j]),
			.sine   (sin_w[j])
		);

		if (j == 0) begin : g_direct
			assign cell_cos[j] = cos_w[j];
			assign cell_sin[j] = sin_w[j];
		end else begin : g_delay
			ent_t cos_dly_q [2*j];
			ent_t sin_dly_q [2*j];
			always_ff @(posedge clk) begin
				if (adv) begin
					cos_dly_q[0] <= cos_w[j];
					sin_dly_q[0] <= sin_w[j];
					for (int m = 1; m < 2 * j; m++) begin
						cos_dly_q[m] <= cos_dly_q[m-1];
						sin_dly_q[m] <= sin_dly_q[m-1];
					end
				end
			end
			assign cell_cos[j] = cos_dly_q[2*j-1];
			assign cell_sin[j] = sin_dly_q[2*j-1];
		end

		assign joint_off[j] = (j == 2) ? shoulder_q : ((j == 4) ? elbow_q : '0);

		afk_joint_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.twist   (TWIST[j]),
			.offset  (joint_off[j]),
			.cosine  (cell_cos[j]),
			.sine    (cell_sin[j]),
			.rot_in  (rot_chain[j]),
			.pos_in  (pos_chain[j]),
			.rot_out (rot_chain[j+1]),
			.pos_out (pos_chain[j+1])
		);
	end

	logic signed [TERM_W-1:0] fterm_s1 [3];
	pos_t                     fpos_s1, fpos_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				fterm_s1[i] <= rot_chain[NUM_JOINTS][i][2] * $signed({1'b0, flange_q});
				fpos_s1[i]  <= pos_chain[NUM_JOINTS][i];
				fpos_s2[i]  <= fpos_s1[i] + round_term(fterm_s1[i]);
			end
		end
	end

	logic signed [POS_W:0]   rnd [3];
	logic signed [OUT_W-1:0] sat [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = ((POS_W+1)'(fpos_s2[i]) + HALF_OUT) >>> OUT_SHIFT;
			if (rnd[i] > (POS_W+1)'(OUT_MAX)) begin
				sat[i] = OUT_MAX;
			end else if (rnd[i] < (POS_W+1)'(OUT_MIN)) begin
				sat[i] = OUT_MIN;
			end else begin
				sat[i] = OUT_W'(rnd[i]);
			end
		end
		result = '{position_x: sat[0], position_y: sat[1], position_z: sat[2]};
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign pose.valid      = count_q != 2'd0;
	assign pose.position_x = fifo_q[rd_ptr_q].position_x;
	assign pose.position_y = fifo_q[rd_ptr_q].position_y;
	assign pose.position_z = fifo_q[rd_ptr_q].position_z;
endmodule

// ===== verif/tb_arm_forward_kinematics_7dof.sv =====
// Testbench for arm_forward_kinematics_7dof: joint angles in, end-effector position out.
// Depends on afk_pkg, afk_in_if and afk_out_if; checks every pose against its own predictor.
module tb_arm_forward_kinematics_7dof;
	import afk_pkg::*;

	typedef logic signed [15:0] angle_t;
	typedef angle_t joint_set_t [7];

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        write_enable;
	logic [1:0]  write_index;
	logic [17:0] write_data;

	afk_in_if #(.ANGLE_WIDTH(16)) joints ();
	afk_out_if pose ();

	arm_forward_kinematics_7dof dut (
		.clk(clk),
		.arst_n(arst_n),
		.joints(joints),
		.pose(pose),
		.write_enable(write_enable),
		.write_index(write_index),
		.write_data(write_data)
	);

	longint     shoulder_q16, elbow_q16, flange_q16;
	out_item_t  expected_pose [$];
	int         mismatches;
	bit         hold_req;
	bit         calm;
	int         stall_left;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint round_half_up(input longint x, input int s);
		longint y;
		y = x + (64'sd1 <<< (s - 1));
		return y >>> s;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic void joint_trig(input longint t, output longint co, output longint si);
		longint k, r, z, p, mag, sr, cr;
		int sin_div [5];
		int cos_div [5];
		sin_div = '{110, 72, 42, 20, 6};
		cos_div = '{90, 56, 30, 12, 2};
		if (t > Q30_PI)
			t = t - 2 * Q30_PI;
		if (t < -Q30_PI)
			t = t + 2 * Q30_PI;
		k = (t + Q30_PI + Q30_QUARTERPI) / Q30_HALFPI - 2;
		r = t - k * Q30_HALFPI;
		mag = (r < 0) ? -r : r;
		z = q30_mul(mag, mag);
		p = Q30_ONE;
		for (int i = 0; i < 5; i++)
			p = Q30_ONE - q30_mul(z, p) / sin_div[i];
		sr = q30_mul(mag, p);
		if (r < 0)
			sr = -sr;
		p = Q30_ONE;
		for (int i = 0; i < 5; i++)
			p = Q30_ONE - q30_mul(z, p) / cos_div[i];
		cr = p;
		case ((k + 4) & 3)
			0: begin co = cr; si = sr; end
			1: begin co = -sr; si = cr; end
			2: begin co = -cr; si = -sr; end
			default: begin co = sr; si = -cr; end
		endcase
	endfunction

	function automatic logic signed [23:0] to_position(input longint p24);
		longint v;
		v = round_half_up(p24, 8);
		if (v > 8388607)
			v = 8388607;
		if (v < -8388608)
			v = -8388608;
		return v[23:0];
	endfunction

	function automatic out_item_t predict_pose(input joint_set_t a);
		bit     flips [6];
		longint rot [3][3];
		longint pos [3];
		longint offs [6];
		longint c, s, ra, rb, re;
		out_item_t res;
		flips = '{1, 0, 0, 1, 1, 0};
		for (int i = 0; i < 3; i++) begin
			pos[i] = 0;
			for (int j = 0; j < 3; j++)
				rot[i][j] = (i == j) ? Q30_ONE : 0;
		end
		for (int j = 0; j < 6; j++)
			offs[j] = 0;
		offs[2] = shoulder_q16 * 256;
		offs[4] = elbow_q16 * 256;
		for (int j = 0; j < 6; j++) begin
			if (offs[j] != 0)
				for (int i = 0; i < 3; i++)
					pos[i] += round_half_up(rot[i][2] * offs[j], 30);
			joint_trig(longint'(a[j]) * 131072, c, s);
			for (int i = 0; i < 3; i++) begin
				ra = rot[i][0];
				rb = rot[i][1];
				re = rot[i][2];
				rot[i][0] = round_half_up(c * ra + s * rb, 30);
				if (flips[j]) begin
					rot[i][1] = re;
					rot[i][2] = round_half_up(s * ra - c * rb, 30);
				end else begin
					rot[i][1] = -re;
					rot[i][2] = round_half_up(c * rb - s * ra, 30);
				end
			end
		end
		for (int i = 0; i < 3; i++)
			pos[i] += round_half_up(rot[i][2] * (flange_q16 * 256), 30);
		res.position_x = to_position(pos[0]);
		res.position_y = to_position(pos[1]);
		res.position_z = to_position(pos[2]);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic angle_t rand_angle();
		case ($urandom_range(0, 3))
			0: return angle_t'($urandom_range(0, 65535));
			1: return angle_t'($urandom_range(0, 8192)) - 16'sd4096;
			2: return ($urandom_range(0, 1) ? 16'sd25736 : -16'sd25736)
				+ angle_t'($urandom_range(0, 16)) - 16'sd8;
			default: return angle_t'($urandom_range(0, 4)) * 16'sd12868
				- 16'sd25736 + angle_t'($urandom_range(0, 4)) - 16'sd2;
		endcase
	endfunction

	task automatic send_pose(input joint_set_t a, input int gap);
		joints.valid             <= 1'b1;
		joints.angle_joint_one   <= a[0];
		joints.angle_joint_two   <= a[1];
		joints.angle_joint_three <= a[2];
		joints.angle_joint_four  <= a[3];
		joints.angle_joint_five  <= a[4];
		joints.angle_joint_six   <= a[5];
		joints.angle_joint_seven <= a[6];
		do @(posedge clk); while (!joints.ready);
		expected_pose.push_back(predict_pose(a));
		if (gap > 0) begin
			joints.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_uniform(input angle_t v);
		joint_set_t a;
		foreach (a[i])
			a[i] = v;
		send_pose(a, pick_gap());
	endtask

	task automatic send_random(input int n);
		joint_set_t a;
		repeat (n) begin
			foreach (a[i])
				a[i] = rand_angle();
			send_pose(a, pick_gap());
		end
	endtask

	task automatic drain();
		joints.valid <= 1'b0;
		while (expected_pose.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(input logic [1:0] idx, input logic [17:0] val);
		write_enable <= 1'b1;
		write_index  <= idx;
		write_data   <= val;
		@(posedge clk);
		write_enable <= 1'b0;
		case (idx)
			REG_SHOULDER: shoulder_q16 = val;
			REG_ELBOW:    elbow_q16 = val;
			REG_FLANGE:   flange_q16 = val;
			default: ;
		endcase
	endtask

	task automatic set_offsets(input logic [17:0] d1, input logic [17:0] d2,
			input logic [17:0] d3);
		write_offset(REG_SHOULDER, d1);
		write_offset(REG_ELBOW, d2);
		write_offset(REG_FLANGE, d3);
	endtask

	task automatic test_directed();
		joint_set_t a;
		send_uniform(16'sd0);
		send_uniform(16'sh7FFF);
		send_uniform(-16'sh8000);
		send_uniform(16'sh5555);
		send_uniform(-16'sh5556);
		send_uniform(16'sd25735);
		send_uniform(16'sd25736);
		send_uniform(-16'sd25736);
		for (int j = 0; j < 6; j++) begin
			foreach (a[i])
				a[i] = 16'sd0;
			a[j] = 16'sd12868;
			send_pose(a, pick_gap());
		end
		foreach (a[i])
			a[i] = 16'sd3000;
		for (int v = 0; v < 4; v++) begin
			a[6] = (v == 0) ? 16'sh7FFF : (v == 1) ? -16'sh8000 : angle_t'($urandom);
			send_pose(a, 0);
		end
		drain();
	endtask

	task automatic test_offsets();
		write_offset(REG_UNUSED, 18'h3FFFF);
		send_random(4);
		drain();
		set_offsets(18'd0, 18'd0, 18'd0);
		send_random(6);
		drain();
		set_offsets(18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
		send_uniform(16'sd0);
		send_random(6);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_offsets(18'd26214, 18'd25559, 18'd13107);
				1: set_offsets(18'($urandom), 18'($urandom), 18'($urandom));
				2: set_offsets(18'd0, 18'($urandom), 18'h3FFFF);
				default: set_offsets(18'h3FFFF, 18'd0, 18'($urandom));
			endcase
			for (int b = 0; b < 4; b++) begin
				calm = (b == 2);
				send_random(80);
			end
			calm = 1'b0;
			drain();
		end
	endtask

	task automatic test_backpressure();
		calm = 1'b1;
		hold_req = 1'b1;
		send_random(60);
		calm = 1'b0;
		drain();
	endtask

	initial begin
		pose.ready = 1'b0;
		hold_req = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pose.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				pose.ready <= 1'b0;
				stall_left--;
			end else begin
				pose.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	initial begin
		out_item_t want;
		mismatches = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pose.valid && pose.ready) begin
				if (expected_pose.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected pose x=%0d y=%0d z=%0d",
							pose.position_x, pose.position_y, pose.position_z);
				end else begin
					want = expected_pose.pop_front();
					if (pose.position_x !== want.position_x
							|| pose.position_y !== want.position_y
							|| pose.position_z !== want.position_z) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pose mismatch exp %0d %0d %0d got %0d %0d %0d",
								want.position_x, want.position_y, want.position_z,
								pose.position_x, pose.position_y, pose.position_z);
					end
				end
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((joints.valid && joints.ready) || (pose.valid && pose.ready) || write_enable)
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("tb_arm_forward_kinematics_7dof NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		write_enable = 1'b0;
		write_index = REG_SHOULDER;
		write_data = '0;
		joints.valid = 1'b0;
		joints.angle_joint_one = '0;
		joints.angle_joint_two = '0;
		joints.angle_joint_three = '0;
		joints.angle_joint_four = '0;
		joints.angle_joint_five = '0;
		joints.angle_joint_six = '0;
		joints.angle_joint_seven = '0;
		calm = 1'b0;
		shoulder_q16 = 26214;
		elbow_q16 = 25559;
		flange_q16 = 13107;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_offsets();
		test_backpressure();
		test_random();
		if (mismatches == 0 && expected_pose.size() == 0)
			$display("tb_arm_forward_kinematics_7dof OK");
		else
			$display("tb_arm_forward_kinematics_7dof NOT OK");
		$finish;
	end
endmodule
